// ===== sv/lurl_pkg.sv =====
// ----------------------------------------------------------------------------
// lurl_pkg
// shared types, sizes and helpers for the longest unique run length block
// ----------------------------------------------------------------------------
package lurl_pkg;

  localparam int POSITION_BITS = 16;
  localparam int ALPHABET_SIZE = 256;
  localparam int SYM_BITS      = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int SYMBOL_W      = 8;
  localparam int LEN_W         = 16;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = QPTR_W + 1;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [SYM_BITS-1:0]      sym_t;
  typedef logic [LEN_W-1:0]         len_t;

  // highest count a string may reach; a symbol arriving at it is not entered
  localparam pos_t POS_LIMIT = '1;
  localparam len_t LEN_MAX   = '1;

  // one classified symbol, passed from front to back
  typedef struct packed {
    pos_t pos;      // position of this symbol in its string
    pos_t prev;     // latest earlier position of the same symbol
    logic seen;     // prev is valid for this string
    logic entered;  // symbol was inside the position range
    logic last;     // final symbol of the string
  } lurl_item_t;

  // fold a byte into the alphabet, restoring subtraction over eight steps
  function automatic sym_t sym_reduce(input logic [SYMBOL_W-1:0] v);
    logic [15:0] r;
    r = {8'd0, v};
    for (int i = 7; i >= 0; i--) begin
      if (r >= (16'(ALPHABET_SIZE) << i)) begin
        r = r - (16'(ALPHABET_SIZE) << i);
      end
    end
    return r[SYM_BITS-1:0];
  endfunction

  function automatic len_t sat_len(input pos_t v);
    if (33'(v) > 33'(LEN_MAX)) begin
      return LEN_MAX;
    end
    return LEN_W'(v);
  endfunction

endpackage

// ===== sv/lurl_front.sv =====
// ----------------------------------------------------------------------------
// lurl_front
// accepts symbols, looks up and updates the last-position table and seen marks
// ----------------------------------------------------------------------------
module lurl_front import lurl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                sym_valid,
  output logic                sym_ready,
  input  logic [SYMBOL_W-1:0] symbol,
  input  logic                end_of_string,
  input  logic [QCNT_W-1:0]   q_level,
  output logic                push,
  output lurl_item_t          push_item
);

  sym_t                     sym;
  logic                     accept;
  logic                     full_pos;
  logic [QCNT_W:0]          occupancy;

  pos_t                     last_position [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] seen_mark;
  pos_t                     count;

  logic                     s1_valid;
  pos_t                     s1_pos;
  pos_t                     prev_rd;
  logic                     s1_seen;
  logic                     s1_entered;
  logic                     s1_last;

  assign sym       = sym_reduce(symbol);
  assign full_pos  = (count == POS_LIMIT);
  // words in the stage register count against the queue space
  assign occupancy = {1'b0, q_level} + {{QCNT_W{1'b0}}, s1_valid};
  assign sym_ready = (occupancy < (QCNT_W + 1)'(QUEUE_DEPTH));
  assign accept    = sym_valid & sym_ready;

  // table read returns the old entry while the new position is written
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_rd <= last_position[sym];
      if (!full_pos) begin
        last_position[sym] <= count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      count     <= '0;
      seen_mark <= '0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (end_of_string) begin
          count     <= '0;
          seen_mark <= '0;
        end else if (!full_pos) begin
          count          <= count + pos_t'(1);
          seen_mark[sym] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos     <= count;
      s1_seen    <= seen_mark[sym];
      s1_entered <= !full_pos;
      s1_last    <= end_of_string;
    end
  end

  assign push              = s1_valid;
  assign push_item.pos     = s1_pos;
  assign push_item.prev    = prev_rd;
  assign push_item.seen    = s1_seen;
  assign push_item.entered = s1_entered;
  assign push_item.last    = s1_last;

endmodule

// ===== sv/lurl_queue.sv =====
// ----------------------------------------------------------------------------
// lurl_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
module lurl_queue import lurl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lurl_item_t        push_item,
  input  logic              pop,
  output logic              head_valid,
  output lurl_item_t        head,
  output logic [QCNT_W-1:0] level
);

  lurl_item_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign head_valid = (level != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   level <= level + QCNT_W'(1);
        2'b01:   level <= level - QCNT_W'(1);
        default: level <= level;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> (level != QCNT_W'(QUEUE_DEPTH)))
    else $error("queue written while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> (level != '0))
    else $error("queue read while empty");
`endif

endmodule

// ===== sv/lurl_back.sv =====
// ----------------------------------------------------------------------------
// lurl_back
// window and best-length update, result register
// ----------------------------------------------------------------------------
module lurl_back import lurl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  lurl_item_t head,
  output logic       pop,
  output logic       res_valid,
  input  logic       res_ready,
  output len_t       longest_length,
  output logic       too_long
);

  pos_t window_start;
  pos_t best_length;
  logic overflowed;

  logic can_take;
  logic ws_hit;
  pos_t ws_moved;
  pos_t run;
  pos_t window_start_next;
  pos_t best_length_next;
  logic overflowed_next;

  assign can_take = !res_valid || res_ready;
  // only a final symbol needs the result register
  assign pop      = head_valid && (!head.last || can_take);

  always_comb begin
    ws_hit            = head.seen && (head.prev >= window_start);
    ws_moved          = ws_hit ? head.prev + pos_t'(1) : window_start;
    run               = head.pos - ws_moved + pos_t'(1);
    window_start_next = head.entered ? ws_moved : window_start;
    best_length_next  = (head.entered && (run > best_length)) ? run : best_length;
    overflowed_next   = overflowed | !head.entered;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid    <= 1'b0;
      window_start <= '0;
      best_length  <= '0;
      overflowed   <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (pop) begin
        if (head.last) begin
          res_valid    <= 1'b1;
          window_start <= '0;
          best_length  <= '0;
          overflowed   <= 1'b0;
        end else begin
          window_start <= window_start_next;
          best_length  <= best_length_next;
          overflowed   <= overflowed_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      longest_length <= sat_len(best_length_next);
      too_long       <= overflowed_next;
    end
  end

`ifndef ASSERT_OFF
  a_string_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && head.last) |=> (window_start == '0 && best_length == '0 && !overflowed))
    else $error("string state not cleared after final word");

  a_best_grows: assert property (@(posedge clk) disable iff (rst)
    (pop && !head.last && head.entered) |=> (best_length != '0))
    else $error("best length zero after an entered symbol");
`endif

endmodule

// ===== sv/longest_unique_run_length.sv =====
// ----------------------------------------------------------------------------
// longest_unique_run_length
// length of the longest run of distinct bytes in each string of a byte stream
// ----------------------------------------------------------------------------
// input channel s_axis: one byte per word in tdata, tlast on the final byte
// of a string. output channel m_axis: one word per string, tdata holds the
// longest run length (saturated), tuser flags a string that ran past the
// position range (symbols beyond it are dropped from the window).
// throughput: one byte per cycle while the queue has room. the front reads
// and rewrites the last-position table in the same cycle (single port, old
// data on read), so no byte waits on the one before it; the back keeps window
// start, best length and overrun flag, a compare and subtract per cycle.
// the final byte passes stage register and queue, then the result register.
// when m_axis stalls, bytes keep flowing until the 4-word queue between
// front and back fills; a stalled result only blocks the next final byte.
// reset: seen marks are flip-flops cleared at once, no clearing pass; the
// block takes bytes in the first cycle after reset.
// ----------------------------------------------------------------------------
module longest_unique_run_length import lurl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SYMBOL_W-1:0] s_axis_tdata,   // [7:0] symbol
  input  logic                s_axis_tlast,   // end_of_string
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [LEN_W-1:0]    m_axis_tdata,   // [15:0] longest_length
  output logic [0:0]          m_axis_tuser    // [0] too_long
);

  logic              push;
  lurl_item_t        push_item;
  logic              pop;
  logic              head_valid;
  lurl_item_t        head;
  logic [QCNT_W-1:0] q_level;
  logic              too_long;

  // front: table lookup and classification of each byte
  lurl_front u_front (
    .clk           (clk),
    .rst           (rst),
    .sym_valid     (s_axis_tvalid),
    .sym_ready     (s_axis_tready),
    .symbol        (s_axis_tdata),
    .end_of_string (s_axis_tlast),
    .q_level       (q_level),
    .push          (push),
    .push_item     (push_item)
  );

  // decoupling queue
  lurl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .level      (q_level)
  );

  // back: window tracking and result word
  lurl_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .res_valid      (m_axis_tvalid),
    .res_ready      (m_axis_tready),
    .longest_length (m_axis_tdata),
    .too_long       (too_long)
  );

  assign m_axis_tuser = too_long;

endmodule

// ===== tb/longest_unique_run_length_tb.sv =====
// ----------------------------------------------------------------------------
// longest_unique_run_length_tb
// self-checking bench: byte strings go in on s_axis, and each result word on
// m_axis is compared with a typed row value or a run tracker kept in the
// bench. a short table of known strings comes first, then random strings
// drawn from narrow and full byte ranges, with random stalls on both channels
// ----------------------------------------------------------------------------
module longest_unique_run_length_tb;
  import lurl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RAND_BYTES     = 415;
  localparam int unsigned RAND_STRINGS   = 20;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned TAIL_CYCLES    = 8;
  localparam int unsigned N_ROWS         = 9;

  // one result word: run length and overrun flag
  typedef struct packed {
    len_t run_len;
    logic too_long;
  } run_report_t;

  typedef enum logic [1:0] {PAT_TEXT, PAT_SAME, PAT_STEP} pattern_e;

  // one directed string; text holds up to eight chars, first char highest
  typedef struct {
    pattern_e    pat;
    int unsigned count;
    logic [63:0] text;
    logic [7:0]  base;
    logic [7:0]  stride;
    bit          typed;
    len_t        want_len;
    logic        want_over;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [SYMBOL_W-1:0] s_axis_tdata  = '0;   // [7:0] symbol
  logic                s_axis_tlast  = 1'b0; // end_of_string
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [LEN_W-1:0]    m_axis_tdata;         // [15:0] longest_length
  logic [0:0]          m_axis_tuser;         // [0] too_long

  logic word_moved;

  // run tracker state, one copy of what the block keeps per string
  pos_t last_pos [ALPHABET_SIZE];
  logic seen_sym [ALPHABET_SIZE];
  pos_t win_start;
  pos_t sym_count;
  pos_t best_run;
  logic ran_over;

  run_report_t report_q[$];   // result words still owed by the block
  run_report_t want;

  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;

  int unsigned bytes_sent   = 0;
  int unsigned strings_sent = 0;
  int unsigned words_seen   = 0;
  int unsigned over_seen    = 0;
  int unsigned fail_count   = 0;

  // directed strings; typed expectations only where obvious by eye
  row_t dir_rows [N_ROWS] = '{
    // lowest byte alone, right after reset
    '{PAT_SAME, 1,     64'h0,      8'h00, 8'h00, 1'b1, 16'd1,   1'b0},
    // highest byte alone
    '{PAT_SAME, 1,     64'h0,      8'hFF, 8'h00, 1'b1, 16'd1,   1'b0},
    '{PAT_TEXT, 8,     "abcabcbb", 8'h00, 8'h00, 1'b1, 16'd3,   1'b0},
    '{PAT_TEXT, 6,     "pwwkew",   8'h00, 8'h00, 1'b1, 16'd3,   1'b0},
    // earlier 'a' is already left of the window, start must not move back
    '{PAT_TEXT, 4,     "abba",     8'h00, 8'h00, 1'b1, 16'd2,   1'b0},
    '{PAT_TEXT, 4,     "dvdf",     8'h00, 8'h00, 1'b1, 16'd3,   1'b0},
    // same byte over and over
    '{PAT_SAME, 4,     64'h0,      8'hA5, 8'h00, 1'b1, 16'd1,   1'b0},
    // stepping past 0xff wraps the byte value
    '{PAT_STEP, 5,     64'h0,      8'hF0, 8'h11, 1'b0, 16'd0,   1'b0},
    // marks cleared between strings
    '{PAT_SAME, 1,     64'h0,      8'h5A, 8'h00, 1'b1, 16'd1,   1'b0}
  };

  longest_unique_run_length DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  assign word_moved = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready);

  // mostly no gap, some short ones, a few long
  function automatic int unsigned pick_gap(input bit enable);
    int unsigned r;
    if (!enable) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // per-string state goes back to empty; last positions stay as they are
  function automatic void clear_string();
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      seen_sym[i] = 1'b0;
    end
    win_start = '0;
    sym_count = '0;
    best_run  = '0;
    ran_over  = 1'b0;
  endfunction

  // take one byte into the run tracker; done is set when a result word is due
  task automatic track_symbol(input logic [SYMBOL_W-1:0] sym_in, input logic is_last,
                              output logic done, output run_report_t rep);
    int   s;
    pos_t run;
    s = int'(sym_in) % ALPHABET_SIZE;
    if (sym_count < POS_LIMIT) begin
      // repeat inside the window: window restarts just past the older copy
      if (seen_sym[s] && last_pos[s] >= win_start) begin
        win_start = last_pos[s] + pos_t'(1);
      end
      last_pos[s] = sym_count;
      seen_sym[s] = 1'b1;
      run = sym_count - win_start + pos_t'(1);
      if (run > best_run) begin
        best_run = run;
      end
      sym_count = sym_count + pos_t'(1);
    end else begin
      // past the position range: byte dropped, string flagged
      ran_over = 1'b1;
    end
    done = is_last;
    rep.run_len  = (32'(best_run) > 32'(LEN_MAX)) ? LEN_MAX : LEN_W'(best_run);
    rep.too_long = ran_over;
    if (is_last) begin
      clear_string();
    end
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  // entered and left just after a falling edge; tvalid stays high on return
  task automatic send_word(input logic [SYMBOL_W-1:0] sym_in, input logic is_last,
                           input bit use_hint, input run_report_t hint);
    int unsigned gap;
    logic        done;
    run_report_t got;
    gap = pick_gap(tx_idle);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = sym_in;
    s_axis_tlast  = is_last;
    do @(posedge clk); while (!s_axis_tready);
    track_symbol(sym_in, is_last, done, got);
    if (done) begin
      report_q = {report_q, (use_hint ? hint : got)};
      strings_sent++;
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  // sender holds off until every owed result word is out
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // result side: ready drops for random stretches
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        m_axis_tready = 1'b0;
        hold--;
      end else begin
        m_axis_tready = 1'b1;
        hold = pick_gap(rx_idle);
      end
    end
  end

  // each result word against the oldest owed one
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (report_q.size() == 0) begin
        note_failure($sformatf("result word with none owed: length %0d, too_long %0d",
                               m_axis_tdata, m_axis_tuser[0]));
      end else begin
        want = report_q.pop_front();
        words_seen++;
        if (m_axis_tuser[0]) begin
          over_seen++;
        end
        if (m_axis_tdata !== want.run_len) begin
          note_failure($sformatf("longest_length: expected %0d, got %0d",
                                 want.run_len, m_axis_tdata));
        end
        if (m_axis_tuser[0] !== want.too_long) begin
          note_failure($sformatf("too_long: expected %0d, got %0d",
                                 want.too_long, m_axis_tuser[0]));
        end
      end
    end
  end

  // watchdog: too long with no word moving on either channel
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || word_moved) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no word moved for %0d cycles, %0d result words owed",
             WATCHDOG_LIMIT, report_q.size());
    $display("longest_unique_run_length_tb failed");
    $finish;
  end

  initial begin
    logic [SYMBOL_W-1:0] sym;
    run_report_t         hint;
    int unsigned         len;
    int unsigned         pick;
    int unsigned         rand_bytes;
    int unsigned         rand_strings;
    int unsigned         spread;
    logic [7:0]          lo;
    bit                  narrow;

    rand_bytes   = 0;
    rand_strings = 0;
    clear_string();
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // directed table, sender gaps on, receiver stalls on every other row
    for (int r = 0; r < N_ROWS; r++) begin
      tx_idle = 1'b1;
      rx_idle = (r % 2 == 1);
      hint.run_len  = dir_rows[r].want_len;
      hint.too_long = dir_rows[r].want_over;
      for (int unsigned i = 0; i < dir_rows[r].count; i++) begin
        case (dir_rows[r].pat)
          PAT_TEXT: begin
            sym = dir_rows[r].text[8*(dir_rows[r].count-1-i) +: 8];
          end
          PAT_SAME: begin
            sym = dir_rows[r].base;
          end
          default: begin
            sym = dir_rows[r].base + 8'(i * dir_rows[r].stride);
          end
        endcase
        send_word(sym, i == dir_rows[r].count - 1, dir_rows[r].typed, hint);
      end
    end
    drain_results();

    // random strings: narrow ranges give many repeats, full range few
    while (rand_bytes < RAND_BYTES || rand_strings < RAND_STRINGS) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        len = $urandom_range(1, 12);
      end else if (pick < 19) begin
        len = $urandom_range(13, 40);
      end else begin
        len = $urandom_range(41, 120);
      end
      narrow = ($urandom_range(0, 2) != 0);
      lo     = 8'($urandom_range(0, 255));
      spread = $urandom_range(1, 12);
      for (int unsigned i = 0; i < len; i++) begin
        sym = narrow ? lo + 8'($urandom_range(0, spread)) : 8'($urandom_range(0, 255));
        send_word(sym, i == len - 1, 1'b0, '0);
      end
      rand_bytes += len;
      rand_strings++;
      if (rand_strings % 12 == 0) begin
        drain_results();
      end
    end

    s_axis_tvalid = 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d strings, %0d bytes; %0d result words checked, %0d with overrun",
             strings_sent, bytes_sent, words_seen, over_seen);
    $display("mismatches or stray words: %0d", fail_count);
    if (fail_count == 0) begin
      $display("longest_unique_run_length_tb passed");
    end else begin
      $display("longest_unique_run_length_tb failed");
    end
    $finish;
  end

endmodule
